FILE: hw/rtl/ptt_pkg.sv
// Shared constants, codes and result type of the two-level page table translator.
package ptt_pkg;

   // Field widths of the request and result items.
   localparam int VA_W       = 32;
   localparam int RAW_IDX_W  = 10;
   localparam int STATUS_W   = 3;
   localparam int FRAME_W    = 7;
   localparam int PA_W       = 19;
   localparam int LIMIT_W    = 8;
   localparam int RSP_DATA_W = 32;

   // Defaults of the top-level parameters.
   localparam int DEF_TABLE_ENTRIES = 1024;
   localparam int DEF_MAX_FRAMES    = 128;
   localparam int DEF_OFFSET_BITS   = 12;

   // Frame limit after reset.
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd100;

   // Fixed-point shift of the reciprocal used to fold indices into the table size.
   localparam int RED_SHIFT = 2 * RAW_IDX_W;

   // Request operations.
   localparam logic OP_MAP       = 1'b0;
   localparam logic OP_TRANSLATE = 1'b1;

   // Result status codes.
   localparam logic [STATUS_W-1:0] ST_MAPPED     = 3'd0;
   localparam logic [STATUS_W-1:0] ST_ALREADY    = 3'd1;
   localparam logic [STATUS_W-1:0] ST_NO_FRAME   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_NO_DIR     = 3'd3;
   localparam logic [STATUS_W-1:0] ST_PAGE_INVAL = 3'd4;
   localparam logic [STATUS_W-1:0] ST_TRANSLATED = 3'd5;

   // One result item as it passes from the engine to the output register.
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [FRAME_W-1:0]  frame_number;
      logic [PA_W-1:0]     physical_address;
   } result_type;

endpackage

FILE: hw/rtl/two_level_page_table_translate.sv
// Top level of the two-level page table translator: ports, frame limit register, result register.
//
//  Channel  Direction  Handshake              Contents
//  req      in         req_tvalid/req_tready  tuser: operation; tdata: virtual address
//  rsp      out        rsp_tvalid/rsp_tready  tuser: status; tdata: frame, physical address
//  csr      in         csr_wr_en              csr_wr_data: frame limit
//
// Each request passes from its transfer through S_DIV and S_MOD, a reciprocal fold of the
// indices in two halves, S_READ, a read of the directory and page memories, and S_CHECK,
// a dependent read of the frame owner memory, to S_EXEC, in which the result is handed
// over to the output register. The engine takes no new request until it has handed over
// the last result and returned to idle.
// After reset a clearing pass writes every directory entry with req_tready low. A result
// waiting on rsp_tready does not stop the next request transfer; the engine then holds its
// finished result until the output register frees.
module two_level_page_table_translate #(
   parameter int TABLE_ENTRIES = ptt_pkg::DEF_TABLE_ENTRIES,
   parameter int MAX_FRAMES    = ptt_pkg::DEF_MAX_FRAMES,
   parameter int OFFSET_BITS   = ptt_pkg::DEF_OFFSET_BITS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [ptt_pkg::VA_W-1:0]         req_tdata,    // [31:0] virtual_address
   input  logic [0:0]                       req_tuser,    // [0] operation
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [ptt_pkg::RSP_DATA_W-1:0]   rsp_tdata,    // [6:0] frame_number,
                                                          // [25:7] physical_address
   output logic [ptt_pkg::STATUS_W-1:0]     rsp_tuser,    // [2:0] status
   input  logic                             csr_wr_en,
   input  logic [ptt_pkg::LIMIT_W-1:0]      csr_wr_data   // [7:0] frame_limit
);
   import ptt_pkg::*;

   logic [LIMIT_W-1:0] frame_limit_ff;
   logic               rsp_valid_ff;
   result_type         rsp_ff;
   result_type         res;
   logic               res_valid, res_ready;

   ptt_engine #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .MAX_FRAMES    (MAX_FRAMES),
      .OFFSET_BITS   (OFFSET_BITS)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_op      (req_tuser[0]),
      .req_va      (req_tdata),
      .frame_limit (frame_limit_ff),
      .res_valid   (res_valid),
      .res_ready   (res_ready),
      .res         (res)
   );

   // Frame limit register.
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_limit_ff <= LIMIT_RESET;
      end else if (csr_wr_en) begin
         frame_limit_ff <= csr_wr_data;
      end
   end

   // Output register; it takes a new result when empty or when its transfer completes.
   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_ready) begin
         rsp_valid_ff <= res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (res_ready && res_valid) begin
         rsp_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.status;
   assign rsp_tdata  = RSP_DATA_W'({rsp_ff.physical_address, rsp_ff.frame_number});

endmodule

FILE: hw/rtl/ptt_ram.sv
// Generic simple dual-port synchronous RAM with a registered read port.
module ptt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  logic [WIDTH-1:0]           wr_data,
   input  logic                       rd_en,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic [WIDTH-1:0]           rd_data
);

   bit [WIDTH-1:0] mem_ff [DEPTH];
   bit [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port; the data holds until the next enabled read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/ptt_engine.sv
// Lookup and allocation engine: index folding, table memories and the request sequencer.
module ptt_engine #(
   parameter int TABLE_ENTRIES = 1024,
   parameter int MAX_FRAMES    = 128,
   parameter int OFFSET_BITS   = 12
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_op,
   input  logic [ptt_pkg::VA_W-1:0]     req_va,
   input  logic [ptt_pkg::LIMIT_W-1:0]  frame_limit,
   output logic                         res_valid,
   input  logic                         res_ready,
   output ptt_pkg::result_type          res
);
   import ptt_pkg::*;

   localparam int IW      = $clog2(TABLE_ENTRIES);
   localparam int FW      = $clog2(MAX_FRAMES);
   localparam int FCW     = $clog2(MAX_FRAMES + 1);
   localparam int SLOT_W  = 2 * IW;
   localparam int RECIP   = (1 << RED_SHIFT) / TABLE_ENTRIES;
   localparam int RECIP_W = $clog2(RECIP + 1);
   localparam int PROD_W  = RAW_IDX_W + RECIP_W;
   localparam int Q_W     = PROD_W - RED_SHIFT;

   // Sequencer states.
   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_DIV   = 3'd2;
   localparam logic [2:0] S_MOD   = 3'd3;
   localparam logic [2:0] S_READ  = 3'd4;
   localparam logic [2:0] S_CHECK = 3'd5;
   localparam logic [2:0] S_EXEC  = 3'd6;

   logic [2:0]             state_ff, state_in;
   logic [IW-1:0]          clr_idx_ff;
   logic                   op_ff;
   logic [RAW_IDX_W-1:0]   dir_raw_ff, tbl_raw_ff;
   logic [OFFSET_BITS-1:0] offset_ff;
   logic [PROD_W-1:0]      dir_prod_ff, tbl_prod_ff;
   logic [IW-1:0]          dir_ff, tbl_ff;
   logic [FCW-1:0]         frames_used_ff, frames_used_in;

   logic                   dir_we, dir_re, dir_wdata, dir_rdata;
   logic [IW-1:0]          dir_waddr;
   logic                   page_we, page_re;
   logic [FW-1:0]          page_wdata, page_rdata;
   logic                   fs_we, fs_re;
   logic [SLOT_W-1:0]      fs_rdata;
   logic [SLOT_W-1:0]      slot;
   logic [FW-1:0]          alloc_frame;
   logic                   clearing, page_hit, frames_full, alloc, res_load;

   // Second half of the index fold: remainder from the reciprocal quotient,
   // which is at most one below the true quotient, so one correction suffices.
   function automatic logic [IW-1:0] fold_index(input logic [RAW_IDX_W-1:0] x,
                                                input logic [PROD_W-1:0]    p);
      logic [Q_W-1:0]       q;
      logic [RAW_IDX_W-1:0] qt;
      logic [RAW_IDX_W:0]   r;
      q  = p[PROD_W-1:RED_SHIFT];
      qt = RAW_IDX_W'(q * TABLE_ENTRIES);
      r  = {1'b0, x - qt};
      if (r >= (RAW_IDX_W + 1)'(TABLE_ENTRIES)) begin
         r = r - (RAW_IDX_W + 1)'(TABLE_ENTRIES);
      end
      return IW'(r);
   endfunction

   // Directory presence bits, one per directory entry.
   ptt_ram #(.WIDTH(1), .DEPTH(TABLE_ENTRIES)) u_dir_ram (
      .clock   (clock),
      .wr_en   (dir_we),
      .wr_addr (dir_waddr),
      .wr_data (dir_wdata),
      .rd_en   (dir_re),
      .rd_addr (dir_ff),
      .rd_data (dir_rdata)
   );

   // Frame held by each page slot; meaningful only when the reverse map agrees.
   ptt_ram #(.WIDTH(FW), .DEPTH(1 << SLOT_W)) u_page_ram (
      .clock   (clock),
      .wr_en   (page_we),
      .wr_addr (slot),
      .wr_data (page_wdata),
      .rd_en   (page_re),
      .rd_addr (slot),
      .rd_data (page_rdata)
   );

   // Reverse map: slot that owns each allocated frame.
   ptt_ram #(.WIDTH(SLOT_W), .DEPTH(MAX_FRAMES)) u_owner_ram (
      .clock   (clock),
      .wr_en   (fs_we),
      .wr_addr (alloc_frame),
      .wr_data (slot),
      .rd_en   (fs_re),
      .rd_addr (page_rdata),
      .rd_data (fs_rdata)
   );

   assign clearing    = (state_ff == S_CLEAR);
   assign slot        = {dir_ff, tbl_ff};
   assign alloc_frame = frames_used_ff[FW-1:0];

   // A page is valid when its frame has been handed out and that frame points back to it.
   assign page_hit    = (FCW'(page_rdata) < frames_used_ff) && (fs_rdata == slot);
   assign frames_full = (LIMIT_W'(frames_used_ff) >= frame_limit)
                     || (frames_used_ff >= FCW'(MAX_FRAMES));
   assign alloc       = (op_ff == OP_MAP) && !page_hit && !frames_full;

   assign req_ready = (state_ff == S_IDLE);
   assign res_valid = (state_ff == S_EXEC);
   assign res_load  = res_valid && res_ready;

   // Memory accesses: reads in their own states, writes at result handover or clearing.
   assign dir_re     = (state_ff == S_READ);
   assign page_re    = (state_ff == S_READ);
   assign fs_re      = (state_ff == S_CHECK);
   assign dir_we     = clearing || (res_load && (op_ff == OP_MAP));
   assign dir_waddr  = clearing ? clr_idx_ff : dir_ff;
   assign dir_wdata  = !clearing;
   assign page_we    = res_load && alloc;
   assign fs_we      = page_we;
   assign page_wdata = alloc_frame;

   // Result of the current request.
   always_comb begin
      res = '0;
      if (op_ff == OP_MAP) begin
         if (page_hit) begin
            res.status       = ST_ALREADY;
            res.frame_number = FRAME_W'(page_rdata);
         end else if (frames_full) begin
            res.status = ST_NO_FRAME;
         end else begin
            res.status       = ST_MAPPED;
            res.frame_number = FRAME_W'(alloc_frame);
         end
      end else if (!dir_rdata) begin
         res.status = ST_NO_DIR;
      end else if (!page_hit) begin
         res.status = ST_PAGE_INVAL;
      end else begin
         res.status           = ST_TRANSLATED;
         res.frame_number     = FRAME_W'(page_rdata);
         res.physical_address = PA_W'({page_rdata, offset_ff});
      end
   end

   // Used-frame counter.
   assign frames_used_in = frames_used_ff + FCW'(page_we);

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            if (clr_idx_ff == IW'(TABLE_ENTRIES - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) state_in = S_DIV;
         end
         S_DIV:   state_in = S_MOD;
         S_MOD:   state_in = S_READ;
         S_READ:  state_in = S_CHECK;
         S_CHECK: state_in = S_EXEC;
         S_EXEC: begin
            if (res_ready) state_in = S_IDLE;
         end
         default: state_in = S_CLEAR;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_CLEAR;
         clr_idx_ff     <= '0;
         frames_used_ff <= '0;
      end else begin
         state_ff       <= state_in;
         frames_used_ff <= frames_used_in;
         if (clearing) begin
            clr_idx_ff <= clr_idx_ff + 1'b1;
         end
      end
   end

   // Request capture and the two halves of the index fold.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         op_ff      <= req_op;
         dir_raw_ff <= RAW_IDX_W'(req_va >> (OFFSET_BITS + RAW_IDX_W));
         tbl_raw_ff <= RAW_IDX_W'(req_va >> OFFSET_BITS);
         offset_ff  <= req_va[OFFSET_BITS-1:0];
      end
      if (state_ff == S_DIV) begin
         dir_prod_ff <= PROD_W'(dir_raw_ff * RECIP);
         tbl_prod_ff <= PROD_W'(tbl_raw_ff * RECIP);
      end
      if (state_ff == S_MOD) begin
         dir_ff <= fold_index(dir_raw_ff, dir_prod_ff);
         tbl_ff <= fold_index(tbl_raw_ff, tbl_prod_ff);
      end
   end

`ifndef SYNTH
   // A page entry is written only by an allocating map as its result leaves.
   a_page_write_on_result: assert property (@(posedge clock) disable iff (reset)
      page_we |-> (res_load && (op_ff == OP_MAP)))
      else $error("page entry written outside a map result transfer");

   // The frame counter moves only together with a page allocation.
   a_count_follows_alloc: assert property (@(posedge clock) disable iff (reset)
      !page_we |=> $stable(frames_used_ff))
      else $error("frame counter changed without an allocation");

   // Never more frames handed out than exist.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      frames_used_ff <= FCW'(MAX_FRAMES))
      else $error("frame counter beyond the number of frames");

   // Directory writes come from the clearing pass or from a map result.
   a_dir_write_source: assert property (@(posedge clock) disable iff (reset)
      dir_we |-> (clearing || (res_load && (op_ff == OP_MAP))))
      else $error("directory written outside clearing or a map");
`endif

endmodule

FILE: tb/tb_two_level_page_table_translate.sv
// Self-checking testbench for the two-level page table translator.
module tb_two_level_page_table_translate;
   import ptt_pkg::*;

   localparam int N_ENTRIES  = DEF_TABLE_ENTRIES;
   localparam int N_FRAMES   = DEF_MAX_FRAMES;
   localparam int N_OFFSET   = DEF_OFFSET_BITS;
   localparam int CLK_HALF   = 6;
   localparam int DRAIN_WAIT = 8;

   // Prediction of the page table and the queue of results still owed by the block.
   class page_table_scoreboard;
      bit                  dir_present[N_ENTRIES];
      logic [FRAME_W-1:0]  page_frame[int unsigned];
      int unsigned         frames_used;
      logic [LIMIT_W-1:0]  frame_limit;
      result_type          owed_results[$];
      int unsigned         failures;

      function new();
         frames_used = 0;
         frame_limit = LIMIT_RESET;
         failures    = 0;
      endfunction

      function void set_limit(input logic [LIMIT_W-1:0] value);
         frame_limit = value;
      endfunction

      function int unsigned pending();
         return owed_results.size();
      endfunction

      // Work out the result of an accepted request and update the predicted tables.
      function void note_request(input logic op, input logic [VA_W-1:0] va);
         int unsigned        dir_idx;
         int unsigned        tbl_idx;
         int unsigned        slot;
         int unsigned        eff_limit;
         logic [31:0]        offset;
         logic [31:0]        pa_full;
         result_type         res;
         dir_idx = ((va >> (N_OFFSET + RAW_IDX_W)) & 32'h3FF) % N_ENTRIES;
         tbl_idx = ((va >> N_OFFSET) & 32'h3FF) % N_ENTRIES;
         offset  = va & ((32'd1 << N_OFFSET) - 1);
         slot    = dir_idx * N_ENTRIES + tbl_idx;
         res     = '0;
         if (op == OP_MAP) begin
            eff_limit = (frame_limit > N_FRAMES) ? N_FRAMES : frame_limit;
            // The directory entry becomes present even if the map is then refused.
            dir_present[dir_idx] = 1'b1;
            if (page_frame.exists(slot)) begin
               res.status       = ST_ALREADY;
               res.frame_number = page_frame[slot];
            end else if (frames_used >= eff_limit) begin
               res.status = ST_NO_FRAME;
            end else begin
               page_frame[slot] = frames_used[FRAME_W-1:0];
               res.status       = ST_MAPPED;
               res.frame_number = frames_used[FRAME_W-1:0];
               frames_used      = (frames_used + 1) & 32'hFF;
            end
         end else begin
            if (!dir_present[dir_idx]) begin
               res.status = ST_NO_DIR;
            end else if (!page_frame.exists(slot)) begin
               res.status = ST_PAGE_INVAL;
            end else begin
               pa_full              = ({25'd0, page_frame[slot]} << N_OFFSET) + offset;
               res.status           = ST_TRANSLATED;
               res.frame_number     = page_frame[slot];
               res.physical_address = pa_full[PA_W-1:0];
            end
         end
         owed_results.push_back(res);
      endfunction

      // Compare an accepted result, field by field, with the oldest prediction.
      function void check_result(input logic [STATUS_W-1:0] status,
                                 input logic [RSP_DATA_W-1:0] data);
         result_type want;
         logic [FRAME_W-1:0] got_frame;
         logic [PA_W-1:0]    got_pa;
         got_frame = data[FRAME_W-1:0];
         got_pa    = data[FRAME_W +: PA_W];
         if (owed_results.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual status %0d frame %0d pa 0x%05h",
                     $time, status, got_frame, got_pa);
            failures++;
            return;
         end
         want = owed_results.pop_front();
         if (status !== want.status) begin
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, want.status, status);
            failures++;
         end
         if (got_frame !== want.frame_number) begin
            $display("%0t: frame_number mismatch, expected %0d, actual %0d",
                     $time, want.frame_number, got_frame);
            failures++;
         end
         if (got_pa !== want.physical_address) begin
            $display("%0t: physical_address mismatch, expected 0x%05h, actual 0x%05h",
                     $time, want.physical_address, got_pa);
            failures++;
         end
      endfunction
   endclass

   logic                    clock       = 1'b0;
   logic                    reset       = 1'b1;
   logic                    req_tvalid  = 1'b0;
   logic                    req_tready;
   logic [VA_W-1:0]         req_tdata   = '0;
   logic [0:0]              req_tuser   = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready  = 1'b0;
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic [STATUS_W-1:0]     rsp_tuser;
   logic                    csr_wr_en   = 1'b0;
   logic [LIMIT_W-1:0]      csr_wr_data = '0;

   page_table_scoreboard sb = new();

   bit          req_burst = 1'b0;
   bit          rsp_burst = 1'b0;
   int unsigned rsp_stall = 0;
   int unsigned dir_pool[8];

   two_level_page_table_translate #(
      .TABLE_ENTRIES (N_ENTRIES),
      .MAX_FRAMES    (N_FRAMES),
      .OFFSET_BITS   (N_OFFSET)
   ) DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #CLK_HALF clock = ~clock;

   // Result side: check each transfer, then hold tready low for a random stall.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_stall = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            sb.check_result(rsp_tuser, rsp_tdata);
            if ($urandom_range(0, 39) == 0) rsp_burst = !rsp_burst;
            rsp_stall = rsp_burst ? 0 : $urandom_range(0, 10);
         end else if (rsp_stall > 0) begin
            rsp_stall--;
         end
         rsp_tready <= (rsp_stall == 0);
      end
   end

   // Offer one request after a random gap and wait for its transfer.
   task automatic send_request(input logic op, input logic [VA_W-1:0] va);
      int unsigned gap;
      gap = req_burst ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid   <= 1'b1;
      req_tuser[0] <= op;
      req_tdata    <= va;
      do @(posedge clock); while (!req_tready);
      sb.note_request(op, va);
      if ($urandom_range(0, 39) == 0) req_burst = !req_burst;
   endtask

   // Let every owed result arrive, then give the pipeline time to settle.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic write_frame_limit(input logic [LIMIT_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      sb.set_limit(value);
   endtask

   // Mostly requests on a small set of pages so that maps and translations meet,
   // with some fully random requests mixed in.
   task automatic run_random(input int unsigned count);
      logic            op;
      logic [VA_W-1:0] va;
      int unsigned     dir_idx;
      int unsigned     tbl_idx;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 99) < 15) begin
            op = 1'($urandom_range(0, 1));
            va = $urandom();
         end else begin
            op      = ($urandom_range(0, 99) < 40) ? OP_MAP : OP_TRANSLATE;
            dir_idx = dir_pool[$urandom_range(0, 7)];
            tbl_idx = $urandom_range(0, 1) ? $urandom_range(0, 47)
                                           : 1023 - $urandom_range(0, 15);
            va      = {dir_idx[9:0], tbl_idx[9:0], 12'($urandom_range(0, 4095))};
         end
         send_request(op, va);
      end
   endtask

   initial begin
      dir_pool = '{0, 1, 511, 512, 1022, 1023,
                   $urandom_range(2, 510), $urandom_range(513, 1021)};
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // No frames at all: every map of a new page is refused.
      write_frame_limit(8'd0);
      send_request(OP_TRANSLATE, 32'h0000_0000);
      send_request(OP_TRANSLATE, 32'hFFFF_FFFF);
      send_request(OP_MAP,       32'hFFFF_FFFF);
      send_request(OP_TRANSLATE, 32'hFFFF_FFFF);
      send_request(OP_MAP,       32'h0000_0000);
      drain_results();

      // A single frame: one map succeeds, the next new page finds none left.
      write_frame_limit(8'd1);
      send_request(OP_MAP,       32'h0000_0ABC);
      send_request(OP_MAP,       32'h0000_0123);
      send_request(OP_MAP,       32'h0000_1000);
      send_request(OP_TRANSLATE, 32'h0000_0FFF);
      send_request(OP_TRANSLATE, 32'h0040_0000);
      drain_results();

      // A limit above the frame count is capped at the frame count.
      write_frame_limit(8'd255);
      send_request(OP_MAP,       32'hFFFF_F000);
      send_request(OP_TRANSLATE, 32'hFFFF_FFFF);
      send_request(OP_MAP,       32'hFFC0_0000);
      send_request(OP_TRANSLATE, 32'hFFC0_0001);
      send_request(OP_TRANSLATE, 32'h0000_1000);
      send_request(OP_MAP,       32'h0000_1555);
      send_request(OP_MAP,       32'h7FFF_FFFF);
      send_request(OP_TRANSLATE, 32'h8000_0000);
      drain_results();

      // Random phases; the second lowers the limit below the frames in use,
      // the later ones run the frame supply out.
      write_frame_limit(8'd40);
      run_random(300);
      drain_results();
      write_frame_limit(8'd10);
      run_random(200);
      drain_results();
      write_frame_limit(LIMIT_RESET);
      run_random(200);
      drain_results();
      write_frame_limit(8'd255);
      run_random(250);
      drain_results();
      write_frame_limit(8'd128);
      run_random(150);
      drain_results();

      if (sb.failures == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #3000000;
      $display("simulation failed");
      $finish;
   end

endmodule

FILE: sim.f
hw/rtl/ptt_pkg.sv
hw/rtl/ptt_ram.sv
hw/rtl/ptt_engine.sv
hw/rtl/two_level_page_table_translate.sv
tb/tb_two_level_page_table_translate.sv
